// File: sv/ngga_pkg.sv
// Shared types, constants and helper functions for the GGA sentence framer.
`timescale 1ns / 1ps
`default_nettype none

package ngga_pkg;

    // Longest sentence, counted from the '$', before it is dropped.
    localparam int MAX_SENTENCE_LEN = 128;
    localparam logic [7:0] LIMIT_INDEX = 8'(MAX_SENTENCE_LEN - 1);

    // Number of stored first characters.
    localparam int NUM_SLOTS = 6;

    // Characters the framer looks for.
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_G      = 8'h47;
    localparam logic [7:0] CHAR_N      = 8'h4E;
    localparam logic [7:0] CHAR_A      = 8'h41;

    // XOR of the fixed header text GNGGA.
    localparam logic [7:0] HEADER_XOR = CHAR_G ^ CHAR_N ^ CHAR_G ^ CHAR_G ^ CHAR_A;

    // Header positions and the index the body starts from.
    localparam logic [2:0] HDR_POS_G1  = 3'd3;
    localparam logic [2:0] HDR_POS_G2  = 3'd4;
    localparam logic [2:0] HDR_POS_A   = 3'd5;
    localparam logic [2:0] HDR_DONE    = 3'd6;
    localparam logic [7:0] BODY_START  = 8'd6;

    // Comma-separated field numbers whose first character is kept.
    localparam logic [3:0] FIELD_NS    = 4'd3;
    localparam logic [3:0] FIELD_EW    = 4'd5;
    localparam logic [3:0] FIELD_FIX   = 4'd6;
    localparam logic [3:0] FIELD_SATS  = 4'd7;
    localparam logic [3:0] FIELD_ALTU  = 4'd10;
    localparam logic [3:0] FIELD_GEOU  = 4'd12;
    localparam logic [3:0] FIELD_MAX   = 4'd15;

    // Slot indexes of the stored characters.
    localparam logic [2:0] SLOT_NS   = 3'd0;
    localparam logic [2:0] SLOT_EW   = 3'd1;
    localparam logic [2:0] SLOT_FIX  = 3'd2;
    localparam logic [2:0] SLOT_SATS = 3'd3;
    localparam logic [2:0] SLOT_ALTU = 3'd4;
    localparam logic [2:0] SLOT_GEOU = 3'd5;

    typedef enum logic [1:0] {
        PH_WAIT,
        PH_HEADER,
        PH_BODY,
        PH_CHECK
    } phase_t;

    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } slot_sel_t;

    typedef struct packed {
        logic                        ok;
        logic [7:0]                  computed;
        logic [7:0]                  received;
        logic [NUM_SLOTS-1:0][7:0]   chars;
    } result_t;

    // Decode one hex digit; anything else reads as zero.
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = 4'(c[3:0] + 4'd9);
        end
        return v;
    endfunction

    // Map a field number onto its storage slot, if it has one.
    function automatic slot_sel_t slot_of_field(input logic [3:0] f);
        slot_sel_t s;
        s.hit = 1'b1;
        s.idx = SLOT_NS;
        unique case (f)
            FIELD_NS:   s.idx = SLOT_NS;
            FIELD_EW:   s.idx = SLOT_EW;
            FIELD_FIX:  s.idx = SLOT_FIX;
            FIELD_SATS: s.idx = SLOT_SATS;
            FIELD_ALTU: s.idx = SLOT_ALTU;
            FIELD_GEOU: s.idx = SLOT_GEOU;
            default:    s.hit = 1'b0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// File: sv/ngga_byte_if.sv
// Channel that carries received bytes into the framer.
`timescale 1ns / 1ps
`default_nettype none

interface ngga_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: sv/ngga_result_if.sv
// Channel that carries one checked sentence result out of the framer.
`timescale 1ns / 1ps
`default_nettype none

interface ngga_result_if;
    logic       valid;
    logic       ready;
    logic       checksum_ok;
    logic [7:0] computed_checksum;
    logic [7:0] received_checksum;
    logic [7:0] hemisphere_ns;
    logic [7:0] hemisphere_ew;
    logic [7:0] fix_char;
    logic [7:0] sats_char;
    logic [7:0] alt_unit_char;
    logic [7:0] geoid_unit_char;

    modport source (
        output valid, checksum_ok, computed_checksum, received_checksum,
        output hemisphere_ns, hemisphere_ew, fix_char, sats_char,
        output alt_unit_char, geoid_unit_char,
        input  ready
    );
    modport sink (
        input  valid, checksum_ok, computed_checksum, received_checksum,
        input  hemisphere_ns, hemisphere_ew, fix_char, sats_char,
        input  alt_unit_char, geoid_unit_char,
        output ready
    );
endinterface

`default_nettype wire

// File: sv/ngga_parser.sv
// Sentence framing state, checksum tracking and field capture for one byte per cycle while accept is high.
`timescale 1ns / 1ps
`default_nettype none

module ngga_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        rx_byte,
    output logic              res_valid,
    output ngga_pkg::result_t res
);
    import ngga_pkg::*;

    phase_t                    phase_reg, phase_next;
    logic [2:0]                header_count_reg, header_count_next;
    logic                      header_match_reg, header_match_next;
    logic [7:0]                sentence_index_reg, sentence_index_next;
    logic [7:0]                running_xor_reg, running_xor_next;
    logic [7:0]                hex_digits_reg, hex_digits_next;
    logic [1:0]                hex_count_reg, hex_count_next;
    logic [3:0]                field_number_reg, field_number_next;
    logic                      field_first_seen_reg, field_first_seen_next;
    logic [NUM_SLOTS-1:0]      pend_valid_reg, pend_valid_next;
    logic [NUM_SLOTS-1:0][7:0] pend_char_reg, pend_char_next;
    logic [NUM_SLOTS-1:0][7:0] stored_reg, stored_next;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_WAIT;
            header_count_reg     <= 3'd0;
            header_match_reg     <= 1'b0;
            sentence_index_reg   <= 8'd0;
            running_xor_reg      <= 8'd0;
            hex_digits_reg       <= 8'd0;
            hex_count_reg        <= 2'd0;
            field_number_reg     <= 4'd0;
            field_first_seen_reg <= 1'b0;
            pend_valid_reg       <= '0;
            pend_char_reg        <= '0;
            stored_reg           <= '0;
        end
        else
        begin
            phase_reg            <= phase_next;
            header_count_reg     <= header_count_next;
            header_match_reg     <= header_match_next;
            sentence_index_reg   <= sentence_index_next;
            running_xor_reg      <= running_xor_next;
            hex_digits_reg       <= hex_digits_next;
            hex_count_reg        <= hex_count_next;
            field_number_reg     <= field_number_next;
            field_first_seen_reg <= field_first_seen_next;
            pend_valid_reg       <= pend_valid_next;
            pend_char_reg        <= pend_char_next;
            stored_reg           <= stored_next;
        end
    end

    // Next state and result for the word taken this cycle.
    always_comb
    begin
        logic       is_eol;
        logic       at_limit;
        logic       match;
        logic [2:0] count;
        logic       ok;
        slot_sel_t  sel;

        is_eol   = (rx_byte == CHAR_CR) || (rx_byte == CHAR_LF);
        at_limit = (sentence_index_reg >= LIMIT_INDEX);
        match    = header_match_reg;
        count    = header_count_reg;
        ok       = 1'b0;
        sel      = slot_of_field(field_number_reg);

        phase_next            = phase_reg;
        header_count_next     = header_count_reg;
        header_match_next     = header_match_reg;
        sentence_index_next   = sentence_index_reg;
        running_xor_next      = running_xor_reg;
        hex_digits_next       = hex_digits_reg;
        hex_count_next        = hex_count_reg;
        field_number_next     = field_number_reg;
        field_first_seen_next = field_first_seen_reg;
        pend_valid_next       = pend_valid_reg;
        pend_char_next        = pend_char_reg;
        stored_next           = stored_reg;
        res_valid             = 1'b0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_WAIT:
                begin
                    if (rx_byte == CHAR_DOLLAR)
                    begin
                        header_count_next = 3'd1;
                        header_match_next = 1'b1;
                        phase_next        = PH_HEADER;
                    end
                end
                PH_HEADER:
                begin
                    // Talker is free; the sentence type must be GGA.
                    if ((header_count_reg == HDR_POS_G1 || header_count_reg == HDR_POS_G2)
                        && rx_byte != CHAR_G)
                    begin
                        match = 1'b0;
                    end
                    if (header_count_reg == HDR_POS_A && rx_byte != CHAR_A)
                    begin
                        match = 1'b0;
                    end
                    count             = 3'(header_count_reg + 3'd1);
                    header_match_next = match;
                    header_count_next = count;
                    if (count >= HDR_DONE)
                    begin
                        if (match)
                        begin
                            phase_next            = PH_BODY;
                            sentence_index_next   = BODY_START;
                            running_xor_next      = HEADER_XOR;
                            hex_digits_next       = 8'd0;
                            hex_count_next        = 2'd0;
                            field_number_next     = 4'd0;
                            field_first_seen_next = 1'b0;
                            pend_valid_next       = '0;
                            pend_char_next        = '0;
                        end
                        else
                        begin
                            phase_next = PH_WAIT;
                        end
                    end
                end
                PH_BODY:
                begin
                    sentence_index_next = 8'(sentence_index_reg + 8'd1);
                    priority if (rx_byte == CHAR_STAR)
                    begin
                        phase_next = PH_CHECK;
                    end
                    else if (is_eol || at_limit)
                    begin
                        phase_next = PH_WAIT;
                    end
                    else
                    begin
                        running_xor_next = running_xor_reg ^ rx_byte;
                        priority if (rx_byte == CHAR_COMMA)
                        begin
                            if (field_number_reg < FIELD_MAX)
                            begin
                                field_number_next = 4'(field_number_reg + 4'd1);
                            end
                            field_first_seen_next = 1'b0;
                        end
                        else if (!field_first_seen_reg)
                        begin
                            // First character of a field we keep.
                            for (int i = 0; i < NUM_SLOTS; i++)
                            begin
                                if (sel.hit && sel.idx == 3'(i))
                                begin
                                    pend_valid_next[i] = 1'b1;
                                    pend_char_next[i]  = rx_byte;
                                end
                            end
                            field_first_seen_next = 1'b1;
                        end
                        else
                        begin
                            field_first_seen_next = 1'b1;
                        end
                    end
                end
                PH_CHECK:
                begin
                    sentence_index_next = 8'(sentence_index_reg + 8'd1);
                    if (!is_eol)
                    begin
                        if (at_limit)
                        begin
                            phase_next = PH_WAIT;
                        end
                        else if (hex_count_reg < 2'd2)
                        begin
                            hex_digits_next = {hex_digits_reg[3:0], hex_value(rx_byte)};
                            hex_count_next  = 2'(hex_count_reg + 2'd1);
                        end
                    end
                    else
                    begin
                        // Line end closes the sentence; missing digits read as zero.
                        phase_next = PH_WAIT;
                        unique case (hex_count_reg)
                            2'd0:    hex_digits_next = 8'd0;
                            2'd1:    hex_digits_next = {hex_digits_reg[3:0], 4'd0};
                            default: hex_digits_next = hex_digits_reg;
                        endcase
                        hex_count_next = 2'd2;
                        ok = (hex_digits_next == running_xor_reg);
                        for (int i = 0; i < NUM_SLOTS; i++)
                        begin
                            if (ok && pend_valid_reg[i])
                            begin
                                stored_next[i] = pend_char_reg[i];
                            end
                        end
                        res_valid = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_WAIT;
                end
            endcase
        end

        res.ok       = ok;
        res.computed = running_xor_reg;
        res.received = hex_digits_next;
        res.chars    = stored_next;
    end

endmodule

`default_nettype wire

// File: sv/ngga_out_buf.sv
// Two-entry result register with a skid stage in front of the output channel.
`timescale 1ns / 1ps
`default_nettype none

module ngga_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ngga_pkg::result_t push_data,
    output logic              space,
    ngga_result_if.source     sentence
);
    import ngga_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    out_free;

    // The output slot frees when it is empty or being taken.
    assign out_free = !out_valid_reg || sentence.ready;
    assign space    = !skid_valid_reg;

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign sentence.valid             = out_valid_reg;
    assign sentence.checksum_ok       = out_data_reg.ok;
    assign sentence.computed_checksum = out_data_reg.computed;
    assign sentence.received_checksum = out_data_reg.received;
    assign sentence.hemisphere_ns     = out_data_reg.chars[SLOT_NS];
    assign sentence.hemisphere_ew     = out_data_reg.chars[SLOT_EW];
    assign sentence.fix_char          = out_data_reg.chars[SLOT_FIX];
    assign sentence.sats_char         = out_data_reg.chars[SLOT_SATS];
    assign sentence.alt_unit_char     = out_data_reg.chars[SLOT_ALTU];
    assign sentence.geoid_unit_char   = out_data_reg.chars[SLOT_GEOU];

endmodule

`default_nettype wire

// File: sv/nmea_gga_framer_checker_top.sv
// Top level of the GGA sentence framer and checksum checker.
//
//   channel    role   word                         result per word
//   rx         sink   rx_byte, one character       none
//   sentence   source checksums, flag, six chars   at most one
//
// One byte is taken per cycle while rx is ready; its state update and any result
// are worked out in the same cycle and the result is registered at that edge.
// A result leaves through an output register backed by one skid entry, so
// bytes keep flowing while a result waits; rx stalls only when both are full.
// Reset is asynchronous and active low and puts the framer in the wait phase.
`timescale 1ns / 1ps
`default_nettype none

module nmea_gga_framer_checker_top (
    input  logic          clk,
    input  logic          rst_n,
    ngga_byte_if.sink     rx,
    ngga_result_if.source sentence
);
    import ngga_pkg::*;

    logic    accept;
    logic    space;
    logic    res_valid;
    result_t res;

    assign rx.ready = space;
    assign accept   = rx.valid && rx.ready;

    // Framing and checking of each byte.
    ngga_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx.rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result buffering toward the output channel.
    ngga_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (space),
        .sentence  (sentence)
    );

`ifndef NO_ASSERTIONS
    // A stalled input means results are waiting at the output.
    a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        !rx.ready |-> sentence.valid)
        else $error("input stalled with no result on the output");

    // A result into an empty output shows up at the next edge.
    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !sentence.valid |=> sentence.valid)
        else $error("result lost in the output buffer");

    // Results are produced only by a line-end character.
    a_result_on_eol: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (rx.rx_byte == CHAR_CR || rx.rx_byte == CHAR_LF))
        else $error("result produced by a non line-end byte");

    // The pass flag agrees with the two checksums.
    a_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.ok == (res.computed == res.received)))
        else $error("pass flag disagrees with checksums");
`endif

endmodule

`default_nettype wire

// File: test/gga_sentence_checker.sv
// Watches both channels of the GGA framer, predicts each sentence result and compares it.
`timescale 1ns / 1ps

module gga_sentence_checker (
    input  logic    clk,
    input  logic    rst_n,
    ngga_byte_if    rx,
    ngga_result_if  sentence,
    output int      fail_count,
    output int      sentences_pending
);
    import ngga_pkg::*;

    // Predicted framer state.
    phase_t     scan_phase;
    logic [2:0] hdr_pos;
    logic       hdr_good;
    logic [7:0] char_pos;
    logic [7:0] xor_sum;
    logic [7:0] cs_value;
    logic [1:0] cs_digits;
    logic [3:0] field_idx;
    logic       field_started;
    logic [8:0] first_chars_seen [NUM_SLOTS];
    logic [7:0] kept_chars [NUM_SLOTS];

    result_t    expected_sentences [$];
    int         mismatches;

    // Advance the predicted framer by one accepted byte word and queue any result.
    task automatic advance_gga_frame(input logic [7:0] b);
        logic       at_limit;
        logic       eol;
        logic [3:0] nib;
        logic       slot_hit;
        logic [2:0] slot;
        result_t    r;
        at_limit = (char_pos >= LIMIT_INDEX);
        eol = (b == CHAR_CR) || (b == CHAR_LF);
        case (scan_phase)
            PH_WAIT:
            begin
                if (b == CHAR_DOLLAR)
                begin
                    hdr_pos = 3'd1;
                    hdr_good = 1'b1;
                    scan_phase = PH_HEADER;
                end
            end
            PH_HEADER:
            begin
                // Only the last three header characters are checked; a '$' here is plain text.
                if ((hdr_pos == HDR_POS_G1 || hdr_pos == HDR_POS_G2) && b != CHAR_G)
                    hdr_good = 1'b0;
                if (hdr_pos == HDR_POS_A && b != CHAR_A)
                    hdr_good = 1'b0;
                hdr_pos = hdr_pos + 3'd1;
                if (hdr_pos >= HDR_DONE)
                begin
                    if (hdr_good)
                    begin
                        scan_phase = PH_BODY;
                        char_pos = BODY_START;
                        xor_sum = HEADER_XOR;
                        cs_value = 8'd0;
                        cs_digits = 2'd0;
                        field_idx = 4'd0;
                        field_started = 1'b0;
                        for (int i = 0; i < NUM_SLOTS; i++)
                            first_chars_seen[i] = 9'd0;
                    end
                    else
                    begin
                        scan_phase = PH_WAIT;
                    end
                end
            end
            PH_BODY:
            begin
                char_pos = char_pos + 8'd1;
                if (b == CHAR_STAR)
                begin
                    scan_phase = PH_CHECK;
                end
                else if (eol || at_limit)
                begin
                    // Early line end or overlong sentence: dropped silently.
                    scan_phase = PH_WAIT;
                end
                else
                begin
                    xor_sum = xor_sum ^ b;
                    if (b == CHAR_COMMA)
                    begin
                        if (field_idx != FIELD_MAX)
                            field_idx = field_idx + 4'd1;
                        field_started = 1'b0;
                    end
                    else if (!field_started)
                    begin
                        slot_hit = 1'b1;
                        slot = SLOT_NS;
                        case (field_idx)
                            FIELD_NS:   slot = SLOT_NS;
                            FIELD_EW:   slot = SLOT_EW;
                            FIELD_FIX:  slot = SLOT_FIX;
                            FIELD_SATS: slot = SLOT_SATS;
                            FIELD_ALTU: slot = SLOT_ALTU;
                            FIELD_GEOU: slot = SLOT_GEOU;
                            default:    slot_hit = 1'b0;
                        endcase
                        if (slot_hit)
                            first_chars_seen[slot] = {1'b1, b};
                        field_started = 1'b1;
                    end
                end
            end
            default:
            begin
                char_pos = char_pos + 8'd1;
                if (!eol)
                begin
                    if (at_limit)
                    begin
                        scan_phase = PH_WAIT;
                    end
                    else if (cs_digits < 2'd2)
                    begin
                        // Non-hex characters in a digit position count as zero.
                        nib = 4'd0;
                        if (b >= "0" && b <= "9")
                            nib = 4'(b - "0");
                        else if (b >= "A" && b <= "F")
                            nib = 4'(b - "A" + 8'd10);
                        else if (b >= "a" && b <= "f")
                            nib = 4'(b - "a" + 8'd10);
                        cs_value = {cs_value[3:0], nib};
                        cs_digits = cs_digits + 2'd1;
                    end
                end
                else
                begin
                    scan_phase = PH_WAIT;
                    // Missing low digits read as zero.
                    while (cs_digits < 2'd2)
                    begin
                        cs_value = {cs_value[3:0], 4'd0};
                        cs_digits = cs_digits + 2'd1;
                    end
                    r.ok = (cs_value == xor_sum);
                    if (r.ok)
                    begin
                        for (int i = 0; i < NUM_SLOTS; i++)
                            if (first_chars_seen[i][8])
                                kept_chars[i] = first_chars_seen[i][7:0];
                    end
                    r.computed = xor_sum;
                    r.received = cs_value;
                    for (int i = 0; i < NUM_SLOTS; i++)
                        r.chars[i] = kept_chars[i];
                    expected_sentences.push_back(r);
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %02h, got %02h", name, want, got);
            mismatches++;
        end
    endtask

    // Compare any result word first, then feed the accepted byte word to the prediction.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            scan_phase = PH_WAIT;
            hdr_pos = 3'd0;
            hdr_good = 1'b0;
            char_pos = 8'd0;
            xor_sum = 8'd0;
            cs_value = 8'd0;
            cs_digits = 2'd0;
            field_idx = 4'd0;
            field_started = 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                first_chars_seen[i] = 9'd0;
                kept_chars[i] = 8'd0;
            end
            expected_sentences.delete();
        end
        else
        begin
            if (sentence.valid && sentence.ready)
            begin
                if (expected_sentences.size() == 0)
                begin
                    $error("sentence result word arrived with none expected");
                    mismatches++;
                end
                else
                begin
                    want = expected_sentences.pop_front();
                    check_field("checksum_ok", 8'(want.ok), 8'(sentence.checksum_ok));
                    check_field("computed_checksum", want.computed, sentence.computed_checksum);
                    check_field("received_checksum", want.received, sentence.received_checksum);
                    check_field("hemisphere_ns", want.chars[SLOT_NS], sentence.hemisphere_ns);
                    check_field("hemisphere_ew", want.chars[SLOT_EW], sentence.hemisphere_ew);
                    check_field("fix_char", want.chars[SLOT_FIX], sentence.fix_char);
                    check_field("sats_char", want.chars[SLOT_SATS], sentence.sats_char);
                    check_field("alt_unit_char", want.chars[SLOT_ALTU], sentence.alt_unit_char);
                    check_field("geoid_unit_char", want.chars[SLOT_GEOU],
                                sentence.geoid_unit_char);
                end
            end
            if (rx.valid && rx.ready)
                advance_gga_frame(rx.rx_byte);
        end
        fail_count <= mismatches;
        sentences_pending <= expected_sentences.size();
    end

endmodule

// File: test/tb_top.sv
// Testbench top: clock, reset, byte stimulus, result back-pressure and the final verdict.
`timescale 1ns / 1ps

module tb_top;
    import ngga_pkg::*;

    localparam int SINK_HOLD_CYCLES = 150;
    localparam int BYTES_PER_PHASE  = 240;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       byte_valid = 1'b0;
    logic [7:0] byte_data = 8'd0;
    logic       sink_ready = 1'b0;
    logic       hold_go = 1'b0;
    int         hold_left = 0;
    int         sink_stall_pct = 0;
    int         send_idle_pct = 0;
    int         bytes_sent = 0;

    int checker_fails;
    int sentences_pending;

    logic [7:0] line_q [$];

    int send_idle_by_phase [4] = '{0, 65, 0, 37};
    int sink_stall_by_phase [4] = '{0, 0, 65, 37};

    ngga_byte_if   byte_if ();
    ngga_result_if sentence_if ();

    assign byte_if.valid    = byte_valid;
    assign byte_if.rx_byte  = byte_data;
    assign sentence_if.ready = sink_ready;

    nmea_gga_framer_checker_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (byte_if),
        .sentence (sentence_if)
    );

    gga_sentence_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .rx                  (byte_if),
        .sentence            (sentence_if),
        .fail_count          (checker_fails),
        .sentences_pending   (sentences_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: random stalls, or a long hold-off counted down here.
    always @(posedge clk)
    begin
        if (hold_go)
        begin
            hold_left <= SINK_HOLD_CYCLES;
            sink_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            sink_ready <= 1'b0;
        end
        else
        begin
            sink_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] hex_digit_char(input logic [3:0] n, input bit lower);
        // Offsets put 10 onto 'A' or 'a'.
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        else if (lower)
            return 8'h57 + 8'(n);
        else
            return 8'h37 + 8'(n);
    endfunction

    // Offer every queued byte word in turn, idling at random before each one.
    task automatic send_line();
        while (line_q.size() != 0)
        begin
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                byte_valid <= 1'b0;
                @(posedge clk);
            end
            byte_valid <= 1'b1;
            byte_data <= line_q.pop_front();
            do
                @(posedge clk);
            while (!byte_if.ready);
            bytes_sent++;
        end
    endtask

    // Build one sentence, mostly well formed, with random content and some damage.
    task automatic queue_gga_sentence();
        logic [7:0] body [$];
        logic [7:0] sum;
        logic [7:0] c;
        logic [7:0] code;
        bit         long_body;
        bit         lower;
        int         nfields;
        int         body_len;
        int         roll;
        int         bad_pos;
        // Stray bytes between sentences.
        if ($urandom_range(0, 99) < 20)
            repeat ($urandom_range(1, 4)) line_q.push_back(8'($urandom));
        // Header: talker characters may be anything, GGA is usually right.
        line_q.push_back(CHAR_DOLLAR);
        repeat (2)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
                line_q.push_back(CHAR_DOLLAR);
            else if (roll < 10)
                line_q.push_back(8'($urandom));
            else
                line_q.push_back(8'($urandom_range("A", "Z")));
        end
        if ($urandom_range(0, 99) < 90)
        begin
            push_text("GGA");
        end
        else
        begin
            bad_pos = $urandom_range(0, 2);
            for (int p = 0; p < 3; p++)
                line_q.push_back(p == bad_pos ? 8'($urandom) : (p == 2 ? CHAR_A : CHAR_G));
        end
        // Body: comma fields, some empty, some long runs past the length limit.
        long_body = ($urandom_range(0, 99) < 6);
        body_len = $urandom_range(117, 124);
        nfields = ($urandom_range(0, 99) < 10) ? $urandom_range(14, 20) : $urandom_range(0, 13);
        for (int k = 0; k < nfields || (long_body && body.size() < body_len); k++)
        begin
            body.push_back(CHAR_COMMA);
            repeat ($urandom_range(0, 3))
            begin
                if ($urandom_range(0, 99) < 2)
                begin
                    c = 8'($urandom);
                end
                else
                begin
                    c = 8'($urandom_range(32, 126));
                    if (c == CHAR_STAR || c == CHAR_COMMA)
                        c = CHAR_N;
                end
                body.push_back(c);
            end
        end
        if (long_body)
            while (body.size() > body_len)
                void'(body.pop_back());
        sum = HEADER_XOR;
        foreach (body[i])
        begin
            line_q.push_back(body[i]);
            sum = sum ^ body[i];
        end
        // Line ending before the star.
        if ($urandom_range(0, 99) < 5)
        begin
            line_q.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
            return;
        end
        // Checksum: right in either case, wrong, or a malformed digit run.
        line_q.push_back(CHAR_STAR);
        roll = $urandom_range(0, 99);
        if (roll < 85)
        begin
            code = (roll < 72) ? sum : sum ^ 8'($urandom_range(1, 255));
            lower = (roll >= 55 && roll < 72);
            line_q.push_back(hex_digit_char(code[7:4], lower));
            line_q.push_back(hex_digit_char(code[3:0], lower));
        end
        else
        begin
            repeat ($urandom_range(0, 4))
                line_q.push_back($urandom_range(0, 1) ?
                                 hex_digit_char(4'($urandom), $urandom_range(0, 1)) :
                                 8'($urandom_range(32, 126)));
        end
        line_q.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme bytes while waiting, a minimal passing sentence,
        // a header mismatch and a line that ends in the body.
        line_q.push_back(8'h00);
        line_q.push_back(8'hFF);
        push_text("$GNGGA*48");
        line_q.push_back(CHAR_CR);
        push_text("$GPGGB");
        push_text("$GNGGA,");
        line_q.push_back(CHAR_LF);
        send_line();

        // Random sentences under each idling mix.
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = send_idle_by_phase[ph];
            sink_stall_pct <= sink_stall_by_phase[ph];
            while (bytes_sent < BYTES_PER_PHASE * (ph + 1))
            begin
                queue_gga_sentence();
                send_line();
            end
        end

        // Hold the result side off while short sentences keep coming, so rx backs up.
        send_idle_pct = 0;
        sink_stall_pct <= 0;
        byte_valid <= 1'b0;
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
        repeat (16)
        begin
            push_text("$GNGGA*48");
            line_q.push_back(CHAR_CR);
        end
        send_line();

        // Drain outstanding results, then keep watching for strays before the verdict.
        byte_valid <= 1'b0;
        @(posedge clk);
        while (sentences_pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (checker_fails == 0)
            $display("nmea_gga_framer_checker_top verification clean");
        else
            $display("nmea_gga_framer_checker_top verification failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #3000000;
        $display("nmea_gga_framer_checker_top verification failed");
        $finish;
    end

endmodule
